>>> rtl/core/wav_header_parser_top_assert.svh
// Assertion macros shared by the wav header parser RTL.
// No dependencies; included inside module bodies.
`ifndef WAV_HEADER_PARSER_TOP_ASSERT_SVH
`define WAV_HEADER_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WAVHP_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WAVHP_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/wavhp_pkg.sv
// Package for the wav header parser: constants, codes and payload structs.
// No dependencies.
package wavhp_pkg;

	localparam int HDR_MAX_LEN_DEF = 4096;

	localparam logic [31:0] TAG_RIFF  = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE  = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT   = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA  = 32'h6461_7461;
	localparam logic [31:0] BIG_CHUNK = 32'h0100_0000;
	localparam logic [31:0] MIN_HDR   = 32'd44;
	localparam logic [15:0] FMT_PCM   = 16'h0001;
	localparam logic [15:0] FMT_ALAW  = 16'h0006;
	localparam logic [15:0] FMT_MULAW = 16'h0007;
	localparam logic [9:0]  MS_PER_S  = 10'd1000;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_BAD_RIFF = 3'd1;
	localparam logic [2:0] ST_BAD_FMT = 3'd2;
	localparam logic [2:0] ST_UNSUP   = 3'd3;
	localparam logic [2:0] ST_SHORT   = 3'd4;

	localparam logic [1:0] CODEC_PCM   = 2'd0;
	localparam logic [1:0] CODEC_ALAW  = 2'd1;
	localparam logic [1:0] CODEC_MULAW = 2'd2;

	localparam logic [1:0] TAGS_RIFF_BIT = 2'b01;
	localparam logic [1:0] TAGS_FMT_BIT  = 2'b10;

	// dividend is data_length*1000, at most 42 bits
	localparam int DVD_W = 42;

	typedef struct packed {
		logic [7:0] header_byte;
		logic       last_byte;
	} in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [1:0]  codec;
		logic [15:0] channels;
		logic [31:0] samp_rate;
		logic [15:0] samp_bits;
		logic [15:0] frame_align;
		logic [31:0] bytes_per_second;
		logic [31:0] data_start;
		logic [31:0] data_length;
		logic [31:0] duration_ms;
	} out_t;

	// header summary handed from front to back
	typedef struct packed {
		logic        short_hdr;
		logic [1:0]  tags_ok;
		logic [15:0] format_code;
		logic [15:0] chan;
		logic [31:0] rate;
		logic [15:0] bits;
		logic [31:0] fallback_size;
		logic        found_data;
		logic [31:0] found_offset;
		logic [31:0] found_size;
	} snap_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_ALIGN,
		B_BPS,
		B_LEN,
		B_MUL,
		B_DIV,
		B_DONE
	} back_state_t;

endpackage

>>> rtl/core/wavhp_front.sv
// Front end: consumes header bytes, tracks tags, fields and the chunk walk.
// Depends on wavhp_pkg; emits one snap_t per header on the final byte.
module wavhp_front #(
	parameter int HEADER_MAX_LEN = wavhp_pkg::HDR_MAX_LEN_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  wavhp_pkg::in_t   item,
	output logic             snap_push,
	output wavhp_pkg::snap_t snap
);
	import wavhp_pkg::*;

	localparam int IW = $clog2(HEADER_MAX_LEN + 1);

	logic [IW-1:0] idx_q;
	logic [31:0]   tag_q, size_q, next_q;
	logic [1:0]    tags_q;
	logic [15:0]   fmt_q, chan_q, bits_q;
	logic [31:0]   rate_q, fallback_q, foff_q, fsize_q;
	logic          found_q, stop_q;

	logic [IW-1:0] idx_n;
	logic [31:0]   tag_n, size_n, next_n;
	logic [1:0]    tags_n;
	logic [15:0]   fmt_n, chan_n, bits_n;
	logic [31:0]   rate_n, fallback_n, foff_n, fsize_n;
	logic          found_n, stop_n;

	logic          parse, walking, in_size, at_end;
	logic [32:0]   idx_x, base_x;
	logic [33:0]   t1, t1p, t2, t2p;

	always_comb begin
		parse   = idx_q < IW'(HEADER_MAX_LEN);
		idx_x   = 33'(idx_q);
		base_x  = {1'b0, next_q};
		walking = parse && (idx_q >= IW'(20)) && !found_q && !stop_q;
		in_size = walking && (idx_x >= base_x + 33'd4) && (idx_x <= base_x + 33'd7);
		at_end  = walking && (idx_x == base_x + 33'd7);

		idx_n = parse ? idx_q + IW'(1) : idx_q;
		tag_n = tag_q;
		size_n = size_q;
		next_n = next_q;
		tags_n = tags_q;
		fmt_n = fmt_q;
		chan_n = chan_q;
		bits_n = bits_q;
		rate_n = rate_q;
		fallback_n = fallback_q;
		foff_n = foff_q;
		fsize_n = fsize_q;
		found_n = found_q;
		stop_n = stop_q;

		if (parse) begin
			if (!in_size) begin
				tag_n = {tag_q[23:0], item.header_byte};
			end
			size_n = {item.header_byte, size_q[31:8]};
		end

		// fmt chunk ends at 20 + its size, padded to even
		t1  = 34'd20 + 34'(size_n);
		t1p = t1 + 34'(t1[0]);
		t2  = {2'b00, next_q} + 34'd8 + 34'(size_n);
		t2p = t2 + 34'(t2[0]);

		if (parse) begin
			if (idx_q == IW'(3)) begin
				tags_n = (tag_n == TAG_RIFF) ? TAGS_RIFF_BIT : 2'b00;
			end
			if (idx_q == IW'(11) && tag_n != TAG_WAVE) begin
				tags_n = tags_q & TAGS_FMT_BIT;
			end
			if (idx_q == IW'(15) && tag_n == TAG_FMT) begin
				tags_n = tags_q | TAGS_FMT_BIT;
			end
			if (idx_q == IW'(19)) begin
				if (t1p[33:32] != 2'b00) stop_n = 1'b1;
				else next_n = t1p[31:0];
			end
			if (idx_q == IW'(21)) fmt_n = size_n[31:16];
			if (idx_q == IW'(23)) chan_n = size_n[31:16];
			if (idx_q == IW'(27)) rate_n = size_n;
			if (idx_q == IW'(35)) bits_n = size_n[31:16];
			if (idx_q == IW'(43)) fallback_n = size_n;
		end

		if (at_end) begin
			if (tag_n == TAG_DATA) begin
				found_n = 1'b1;
				foff_n  = next_q + 32'd8;
				fsize_n = size_n;
			end else if (size_n > BIG_CHUNK || t2p[33:32] != 2'b00) begin
				stop_n = 1'b1;
			end else begin
				next_n = t2p[31:0];
			end
		end

		snap_push = take && item.last_byte;
		snap.short_hdr     = 32'(idx_n) < MIN_HDR;
		snap.tags_ok       = tags_n;
		snap.format_code   = fmt_n;
		snap.chan          = chan_n;
		snap.rate          = rate_n;
		snap.bits          = bits_n;
		snap.fallback_size = fallback_n;
		snap.found_data    = found_n;
		snap.found_offset  = foff_n;
		snap.found_size    = fsize_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0; tag_q <= '0; size_q <= '0; next_q <= '0; tags_q <= '0;
			fmt_q <= '0; chan_q <= '0; bits_q <= '0; rate_q <= '0; fallback_q <= '0;
			foff_q <= '0; fsize_q <= '0; found_q <= 1'b0; stop_q <= 1'b0;
		end else if (take) begin
			if (item.last_byte) begin
				idx_q <= '0; tag_q <= '0; size_q <= '0; next_q <= '0; tags_q <= '0;
				fmt_q <= '0; chan_q <= '0; bits_q <= '0; rate_q <= '0; fallback_q <= '0;
				foff_q <= '0; fsize_q <= '0; found_q <= 1'b0; stop_q <= 1'b0;
			end else begin
				idx_q <= idx_n; tag_q <= tag_n; size_q <= size_n; next_q <= next_n;
				tags_q <= tags_n; fmt_q <= fmt_n; chan_q <= chan_n; bits_q <= bits_n;
				rate_q <= rate_n; fallback_q <= fallback_n; foff_q <= foff_n;
				fsize_q <= fsize_n; found_q <= found_n; stop_q <= stop_n;
			end
		end
	end

endmodule

>>> rtl/core/wavhp_fifo.sv
// Two-entry queue of header summaries between front and back.
// Depends on wavhp_pkg and wav_header_parser_top_assert.svh.
module wavhp_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  wavhp_pkg::snap_t wdata,
	input  logic             rd,
	output wavhp_pkg::snap_t rdata,
	output logic             fifo_full,
	output logic             fifo_empty
);
	import wavhp_pkg::*;
	`include "wav_header_parser_top_assert.svh"

	snap_t      mem_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;

	assign fifo_full  = cnt_q == 2'd2;
	assign fifo_empty = cnt_q == 2'd0;
	assign rdata      = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (wr) wptr_q <= !wptr_q;
			if (rd) rptr_q <= !rptr_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

	`WAVHP_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= 2'd2, "fifo count overflow")
	`WAVHP_ASSERT_IMP(a_no_wr_full, clk, arst_n, wr, !fifo_full, "write into full fifo")
	`WAVHP_ASSERT_IMP(a_no_rd_empty, clk, arst_n, rd, !fifo_empty, "read from empty fifo")

endmodule

>>> rtl/core/wavhp_back.sv
// Back end: derives align, byte rate, size correction and duration.
// Depends on wavhp_pkg and wav_header_parser_top_assert.svh.
module wavhp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [31:0]      file_len,
	input  logic             snap_empty,
	input  wavhp_pkg::snap_t snap,
	output logic             snap_pop,
	output logic             empty,
	input  logic             pop,
	output wavhp_pkg::out_t  result
);
	import wavhp_pkg::*;
	`include "wav_header_parser_top_assert.svh"

	localparam int CW = $clog2(DVD_W);

	back_state_t state_q, state_n;

	logic [2:0]       status_q, status_c;
	logic [1:0]       codec_q, codec_c;
	logic [15:0]      chan_q, bits_q, align_q;
	logic [31:0]      rate_q, bps_q, start_q, len_q;
	logic             found_q;
	logic [31:0]      foff_q, fsize_q, fall_q;
	logic [DVD_W-1:0] dvd_q;
	logic [32:0]      rem_q;
	logic [CW-1:0]    cnt_q;
	out_t             out_q;
	logic             out_valid_q;

	logic [28:0]      align_p;
	logic [47:0]      bps_p;
	logic [31:0]      expected;
	logic [32:0]      rem_sh;
	logic             qbit;
	logic             load_out;

	always_comb begin
		if (snap.short_hdr) status_c = ST_SHORT;
		else if ((snap.tags_ok & TAGS_RIFF_BIT) == 2'b00) status_c = ST_BAD_RIFF;
		else if ((snap.tags_ok & TAGS_FMT_BIT) == 2'b00) status_c = ST_BAD_FMT;
		else if (snap.format_code == FMT_PCM || snap.format_code == FMT_ALAW ||
			snap.format_code == FMT_MULAW) status_c = ST_OK;
		else status_c = ST_UNSUP;
		if (snap.format_code == FMT_ALAW) codec_c = CODEC_ALAW;
		else if (snap.format_code == FMT_MULAW) codec_c = CODEC_MULAW;
		else codec_c = CODEC_PCM;
	end

	assign align_p  = chan_q * bits_q[15:3];
	assign bps_p    = rate_q * align_q;
	assign expected = file_len - start_q;
	assign rem_sh   = {rem_q[31:0], dvd_q[DVD_W-1]};
	assign qbit     = rem_sh >= {1'b0, bps_q};
	assign load_out = (state_q == B_DONE) && (!out_valid_q || pop);

	always_comb begin
		state_n  = state_q;
		snap_pop = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (!snap_empty) begin
					snap_pop = 1'b1;
					state_n  = (status_c == ST_OK) ? B_ALIGN : B_DONE;
				end
			end
			B_ALIGN: state_n = B_BPS;
			B_BPS:   state_n = B_LEN;
			B_LEN:   state_n = B_MUL;
			B_MUL:   state_n = (bps_q == '0 || len_q == '0) ? B_DONE : B_DIV;
			B_DIV: begin
				if (cnt_q == CW'(DVD_W - 1)) state_n = B_DONE;
			end
			B_DONE: begin
				if (load_out) state_n = B_IDLE;
			end
			default: state_n = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= B_IDLE;
		else state_q <= state_n;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				status_q <= status_c;
				codec_q  <= (status_c == ST_OK) ? codec_c : CODEC_PCM;
				chan_q   <= (status_c == ST_OK) ? snap.chan : '0;
				rate_q   <= (status_c == ST_OK) ? snap.rate : '0;
				bits_q   <= (status_c == ST_OK) ? snap.bits : '0;
				found_q  <= snap.found_data;
				foff_q   <= snap.found_offset;
				fsize_q  <= snap.found_size;
				fall_q   <= snap.fallback_size;
				align_q  <= '0;
				bps_q    <= '0;
				start_q  <= '0;
				len_q    <= '0;
				dvd_q    <= '0;
			end
			B_ALIGN: align_q <= (align_p[15:0] == '0) ? 16'd1 : align_p[15:0];
			B_BPS: begin
				bps_q   <= bps_p[31:0];
				start_q <= found_q ? foff_q : MIN_HDR;
				len_q   <= found_q ? fsize_q : fall_q;
			end
			B_LEN: begin
				// repair a wrapped size against the known file length
				if (file_len > start_q && (len_q == '0 || len_q > expected ||
					len_q < (expected >> 1))) begin
					len_q <= expected;
				end
			end
			B_MUL: begin
				// duration stays zero when the byte rate is zero
				dvd_q <= (bps_q == '0) ? '0 : DVD_W'(len_q) * DVD_W'(MS_PER_S);
				rem_q <= '0;
				cnt_q <= '0;
			end
			B_DIV: begin
				rem_q <= qbit ? rem_sh - {1'b0, bps_q} : rem_sh;
				dvd_q <= {dvd_q[DVD_W-2:0], qbit};
				cnt_q <= cnt_q + CW'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.status           <= status_q;
			out_q.codec            <= codec_q;
			out_q.channels         <= chan_q;
			out_q.samp_rate        <= rate_q;
			out_q.samp_bits        <= bits_q;
			out_q.frame_align      <= align_q;
			out_q.bytes_per_second <= bps_q;
			out_q.data_start       <= start_q;
			out_q.data_length      <= len_q;
			out_q.duration_ms      <= dvd_q[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (load_out) out_valid_q <= 1'b1;
		else if (pop) out_valid_q <= 1'b0;
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

	`WAVHP_ASSERT_NXT(a_div_end, clk, arst_n,
		state_q == B_DIV && cnt_q == CW'(DVD_W - 1), state_q == B_DONE, "divider overran")
	`WAVHP_ASSERT_IMP(a_align_nz, clk, arst_n,
		out_valid_q && out_q.status == ST_OK, out_q.frame_align != '0, "zero frame align")
	`WAVHP_ASSERT_IMP(a_fail_zero, clk, arst_n,
		out_valid_q && out_q.status != ST_OK, out_q.data_length == '0, "failed header has size")

endmodule

>>> rtl/core/wav_header_parser_top.sv
// Flow: a good header runs the align, byte rate, size repair and multiply states, then the
// divider if data length and byte rate are nonzero; a failed header goes straight to output.
// Throughput: one header byte per cycle while the summary queue has room; the back end
// works on one header at a time, so a run of short headers may wait on it.
// Reset: arst_n asynchronous, active low; clears parse state, queue and the file length.
// Two header summaries may queue between front and back.
// Depends on wavhp_pkg, wavhp_front, wavhp_fifo and wavhp_back.
module wav_header_parser_top #(
	parameter int HEADER_MAX_LEN = wavhp_pkg::HDR_MAX_LEN_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	// byte stream in
	input  logic            push,
	output logic            full,
	input  wavhp_pkg::in_t  item,
	// results out
	output logic            empty,
	input  logic            pop,
	output wavhp_pkg::out_t result,
	// configuration
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [2:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready
);
	import wavhp_pkg::*;

	logic        take;
	logic        snap_push, snap_pop, snap_full, snap_empty;
	snap_t       snap_in, snap_out;
	logic [31:0] file_len_q;

	// file length register lives at byte address 0
	assign pready = 1'b1;
	assign prdata = (paddr == 3'd0) ? file_len_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) file_len_q <= '0;
		else if (psel && penable && pwrite && paddr == 3'd0) file_len_q <= pwdata;
	end

	// a byte is taken only while the summary queue has room
	assign full = snap_full;
	assign take = push && !full;

	wavhp_front #(
		.HEADER_MAX_LEN(HEADER_MAX_LEN)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.item     (item),
		.snap_push(snap_push),
		.snap     (snap_in)
	);

	wavhp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (snap_push),
		.wdata     (snap_in),
		.rd        (snap_pop),
		.rdata     (snap_out),
		.fifo_full (snap_full),
		.fifo_empty(snap_empty)
	);

	// back end: align, byte rate, size repair, serial divide for duration
	wavhp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.file_len  (file_len_q),
		.snap_empty(snap_empty),
		.snap      (snap_out),
		.snap_pop  (snap_pop),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

>>> tb/sv/wav_header_parser_top_tb.sv
// Self-checking bench for wav_header_parser_top: streams RIFF/WAVE headers and
// compares each parse result with a behavioral predictor. Depends on wavhp_pkg.
`timescale 1ns / 100ps

module wav_header_parser_top_tb;
	import wavhp_pkg::*;

	localparam int HDR_LIMIT = HDR_MAX_LEN_DEF;
	localparam logic [2:0] ADDR_FILE_LEN = 3'd0;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	in_t         item;
	logic        empty;
	logic        pop;
	out_t        result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	wav_header_parser_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state, mirrors the parse state of the block
	logic [31:0] p_file_len;
	logic [31:0] p_idx, p_tag, p_size, p_next;
	logic [1:0]  p_tags;
	logic [15:0] p_fmt, p_chan, p_bits;
	logic [31:0] p_rate, p_fallback, p_found_off, p_found_size;
	logic        p_found, p_stopped;

	out_t        parse_queue[$];
	int          errors;
	bit          quiet_tail;  // no idling on either side near the end
	byte         hdr[$];      // header under construction

	function automatic void parse_clear();
		p_idx = 0; p_tag = 0; p_size = 0; p_next = 0; p_tags = 0;
		p_fmt = 0; p_chan = 0; p_bits = 0; p_rate = 0; p_fallback = 0;
		p_found = 0; p_found_off = 0; p_found_size = 0; p_stopped = 0;
	endfunction

	function automatic void parse_byte(logic [31:0] idx, logic [7:0] b);
		logic        walking;
		logic [32:0] base;
		logic        in_size;
		logic [32:0] t;
		walking = idx >= 20 && !p_found && !p_stopped;
		base    = {1'b0, p_next};
		in_size = walking && {1'b0, idx} >= base + 4 && {1'b0, idx} <= base + 7;
		if (!in_size)
			p_tag = {p_tag[23:0], b};
		p_size = {b, p_size[31:8]};
		case (idx)
			3:  p_tags = (p_tag == TAG_RIFF) ? TAGS_RIFF_BIT : 2'b00;
			11: if (p_tag != TAG_WAVE) p_tags &= TAGS_FMT_BIT;
			15: if (p_tag == TAG_FMT) p_tags |= TAGS_FMT_BIT;
			19: begin
				t = 33'd20 + p_size;
				t = t + t[0];
				if (t[32]) p_stopped = 1;
				else p_next = t[31:0];
			end
			21: p_fmt = p_size[31:16];
			23: p_chan = p_size[31:16];
			27: p_rate = p_size;
			35: p_bits = p_size[31:16];
			43: p_fallback = p_size;
			default: ;
		endcase
		if (walking && {1'b0, idx} == base + 7) begin
			if (p_tag == TAG_DATA) begin
				p_found = 1;
				p_found_off = base[31:0] + 8;
				p_found_size = p_size;
			end else begin
				t = base + 8 + p_size;
				t = t + t[0];
				if (p_size > BIG_CHUNK || t[32]) p_stopped = 1;
				else p_next = t[31:0];
			end
		end
	endfunction

	function automatic out_t parse_summary();
		out_t        r;
		logic [31:0] exp_len, align;
		logic [63:0] prod;
		r = '0;
		if (p_idx < MIN_HDR) r.status = ST_SHORT;
		else if (!p_tags[0]) r.status = ST_BAD_RIFF;
		else if (!p_tags[1]) r.status = ST_BAD_FMT;
		else if (p_fmt == FMT_PCM) r.codec = CODEC_PCM;
		else if (p_fmt == FMT_ALAW) r.codec = CODEC_ALAW;
		else if (p_fmt == FMT_MULAW) r.codec = CODEC_MULAW;
		else r.status = ST_UNSUP;
		if (r.status != ST_OK) begin
			r.codec = CODEC_PCM;
			return r;
		end
		align = (32'(p_chan) * 32'(p_bits / 16'd8)) & 32'hFFFF;
		if (align == 0) align = 1;
		r.channels = p_chan;
		r.samp_rate = p_rate;
		r.samp_bits = p_bits;
		r.frame_align = align[15:0];
		r.bytes_per_second = p_rate * align;
		r.data_start = p_found ? p_found_off : MIN_HDR;
		r.data_length = p_found ? p_found_size : p_fallback;
		if (p_file_len > r.data_start) begin
			exp_len = p_file_len - r.data_start;
			if (r.data_length == 0 || r.data_length > exp_len
					|| r.data_length < exp_len / 2)
				r.data_length = exp_len;
		end
		if (r.bytes_per_second != 0 && r.data_length != 0) begin
			prod = 64'(r.data_length) * 1000;
			r.duration_ms = 32'(prod / 64'(r.bytes_per_second));
		end
		return r;
	endfunction

	// called for each accepted byte transaction
	function automatic void predict_byte(in_t it);
		if (p_idx < HDR_LIMIT) begin
			parse_byte(p_idx, it.header_byte);
			p_idx++;
		end
		if (it.last_byte) begin
			parse_queue.push_back(parse_summary());
			parse_clear();
		end
	endfunction

	// input side: accept detection and prediction on the clock edge
	always @(posedge clk)
		if (arst_n && push && !full)
			predict_byte(item);

	// result side: random pop with bursts of stall, check on acceptance
	int pop_hold;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			pop_hold = 0;
		end else begin
			if (pop && !empty) begin
				if (parse_queue.size() == 0) begin
					$display("%0t: unexpected result, actual %h", $time, result);
					errors++;
				end else begin
					out_t e;
					e = parse_queue.pop_front();
					if (e.status != result.status)
						$display("%0t: status exp %0d act %0d", $time, e.status, result.status);
					if (e.codec != result.codec)
						$display("%0t: codec exp %0d act %0d", $time, e.codec, result.codec);
					if (e.channels != result.channels)
						$display("%0t: channels exp %0d act %0d", $time, e.channels,
							result.channels);
					if (e.samp_rate != result.samp_rate)
						$display("%0t: samp_rate exp %0d act %0d", $time, e.samp_rate,
							result.samp_rate);
					if (e.samp_bits != result.samp_bits)
						$display("%0t: samp_bits exp %0d act %0d", $time,
							e.samp_bits, result.samp_bits);
					if (e.frame_align != result.frame_align)
						$display("%0t: frame_align exp %0d act %0d", $time, e.frame_align,
							result.frame_align);
					if (e.bytes_per_second != result.bytes_per_second)
						$display("%0t: bytes_per_second exp %0d act %0d", $time,
							e.bytes_per_second, result.bytes_per_second);
					if (e.data_start != result.data_start)
						$display("%0t: data_start exp %0d act %0d", $time, e.data_start,
							result.data_start);
					if (e.data_length != result.data_length)
						$display("%0t: data_length exp %0d act %0d", $time, e.data_length,
							result.data_length);
					if (e.duration_ms != result.duration_ms)
						$display("%0t: duration_ms exp %0d act %0d", $time, e.duration_ms,
							result.duration_ms);
					if (e != result) errors++;
				end
			end
			if (quiet_tail) begin
				pop <= 1'b1;
			end else if (pop_hold > 0) begin
				pop_hold--;
				pop <= 1'b0;
			end else if ($urandom_range(0, 9) == 0) begin
				pop_hold = $urandom_range(1, 12) - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// one APB write: setup then access, pready is tied high
	task automatic reg_write(logic [2:0] addr, logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		p_file_len = data;
	endtask

	// drive one byte transaction, optional random gap in front
	task automatic send_byte(logic [7:0] b, logic last);
		int gap;
		if (!quiet_tail && $urandom_range(0, 15) == 0) begin
			gap = $urandom_range(1, 12);
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		item <= '{header_byte: b, last_byte: last};
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	task automatic send_header();
		for (int i = 0; i < hdr.size(); i++)
			send_byte(hdr[i], i == hdr.size() - 1);
		push <= 1'b0;
	endtask

	// wait until every result is back, then cover the back-end latency
	task automatic drain();
		push <= 1'b0;
		while (parse_queue.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic put32(logic [31:0] v);
		hdr.push_back(v[7:0]); hdr.push_back(v[15:8]);
		hdr.push_back(v[23:16]); hdr.push_back(v[31:24]);
	endtask

	task automatic put_tag(logic [31:0] v);
		hdr.push_back(v[31:24]); hdr.push_back(v[23:16]);
		hdr.push_back(v[15:8]); hdr.push_back(v[7:0]);
	endtask

	// canonical header with optional extra chunks before data; bad selects a fault
	task automatic build_wave(logic [15:0] fmt, logic [15:0] ch, logic [31:0] rate,
			logic [15:0] bits, logic [31:0] fmt_len, int extra, logic [31:0] dlen,
			int bad, bit with_data);
		int n;
		logic [31:0] sz;
		hdr.delete();
		put_tag(bad == 1 ? 32'h5249_4647 : TAG_RIFF);
		put32($urandom);
		put_tag(bad == 2 ? 32'h5741_5646 : TAG_WAVE);
		put_tag(bad == 3 ? 32'h666D_7421 : TAG_FMT);
		put32(fmt_len);
		hdr.push_back(fmt[7:0]); hdr.push_back(fmt[15:8]);
		hdr.push_back(ch[7:0]); hdr.push_back(ch[15:8]);
		put32(rate);
		put32($urandom); hdr.push_back(8'($urandom)); hdr.push_back(8'($urandom));
		hdr.push_back(bits[7:0]); hdr.push_back(bits[15:8]);
		// pad fmt body out to its declared length if small
		while (hdr.size() < 20 + fmt_len + fmt_len[0] && hdr.size() < 60)
			hdr.push_back(8'($urandom));
		for (int k = 0; k < extra; k++) begin
			sz = $urandom_range(0, 9);
			put_tag($urandom);
			put32(sz);
			n = sz + sz[0];
			repeat (n) hdr.push_back(8'($urandom));
		end
		if (with_data) begin
			put_tag(TAG_DATA);
			put32(dlen);
		end
		repeat ($urandom_range(0, 6)) hdr.push_back(8'($urandom));
	endtask

	task automatic random_header();
		int kind;
		logic [15:0] fmts[4];
		kind = $urandom_range(0, 99);
		fmts = '{FMT_PCM, FMT_ALAW, FMT_MULAW, 16'($urandom)};
		if (kind < 70) begin
			build_wave(fmts[$urandom_range(0, 3)], 16'($urandom_range(0, 9) == 0 ? $urandom :
				$urandom_range(1, 8)), $urandom_range(0, 3) == 0 ? $urandom :
				$urandom_range(8000, 192000), 16'($urandom_range(0, 4) == 0 ? $urandom :
				8 * $urandom_range(1, 4)), $urandom_range(0, 3) == 0 ?
				$urandom_range(16, 40) : 16, $urandom_range(0, 3),
				$urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 100000),
				$urandom_range(0, 9) == 0 ? $urandom_range(1, 3) : 0,
				$urandom_range(0, 7) != 0);
		end else if (kind < 80) begin
			// noise of random length
			hdr.delete();
			repeat ($urandom_range(1, 70)) hdr.push_back(8'($urandom));
		end else if (kind < 90) begin
			// truncated good header
			build_wave(FMT_PCM, 16'd2, 32'd44100, 16'd16, 32'd16, 1, 32'd1000, 0, 1'b1);
			while (hdr.size() > 1 && $urandom_range(0, 2) != 0)
				void'(hdr.pop_back());
		end else begin
			// huge chunk sizes end the walk
			build_wave(FMT_MULAW, 16'd1, 32'd8000, 16'd8, 32'd16, 0, 32'd0, 0, 1'b0);
			put_tag($urandom);
			put32($urandom_range(0, 1) ? 32'hFFFF_FFF0 : 32'h0100_0001);
			put_tag(TAG_DATA);
			put32(32'd500);
		end
	endtask

	// directed table: expected status typed where it is obvious
	typedef struct {
		int         bad;
		logic [15:0] fmt;
		logic [15:0] ch;
		logic [15:0] bits;
		logic [31:0] fmt_len;
		bit         with_data;
		logic [31:0] dlen;
		int         exp_status;  // -1: predictor only
	} dir_row_t;

	dir_row_t dir_rows[] = '{
		'{0, FMT_PCM,   16'd2,     16'd16,    32'd16,         1, 32'd4000,  ST_OK},
		'{0, FMT_ALAW,  16'd1,     16'd8,     32'd16,         1, 32'd0,     ST_OK},
		'{0, FMT_MULAW, 16'hFFFF,  16'hFFFF,  32'd18,         1, 32'hFFFF_FFFF, -1},
		'{0, 16'h0000,  16'd2,     16'd16,    32'd16,         1, 32'd10,    ST_UNSUP},
		'{0, 16'hFFFF,  16'd0,     16'd0,     32'd16,         1, 32'd0,     ST_UNSUP},
		'{1, FMT_PCM,   16'd2,     16'd16,    32'd16,         1, 32'd10,    ST_BAD_RIFF},
		'{2, FMT_PCM,   16'd2,     16'd16,    32'd16,         1, 32'd10,    ST_BAD_RIFF},
		'{3, FMT_PCM,   16'd2,     16'd16,    32'd16,         1, 32'd10,    ST_BAD_FMT},
		'{0, FMT_PCM,   16'd0,     16'd0,     32'hFFFF_FFF0,  1, 32'd10,    -1},
		'{0, FMT_PCM,   16'd1,     16'd7,     32'd17,         0, 32'd0,     -1}
	};

	int n_headers;

	initial begin
		arst_n = 1'b0;
		push = 1'b0; item = '0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		errors = 0;
		quiet_tail = 0;
		p_file_len = 0;
		parse_clear();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, file length unknown
		foreach (dir_rows[i]) begin
			build_wave(dir_rows[i].fmt, dir_rows[i].ch, 32'hFFFF_FFFF, dir_rows[i].bits,
				dir_rows[i].fmt_len, 0, dir_rows[i].dlen, dir_rows[i].bad,
				dir_rows[i].with_data);
			send_header();
			// let the predictor take the final byte before reading its entry
			@(negedge clk);
			if (dir_rows[i].exp_status >= 0
					&& parse_queue[$].status != 3'(dir_rows[i].exp_status)) begin
				$display("%0t: directed row %0d status exp %0d act %0d", $time, i,
					dir_rows[i].exp_status, parse_queue[$].status);
				errors++;
			end
			@(posedge clk);
		end
		// a lone last byte
		send_byte(8'h00, 1'b1);
		push <= 1'b0;
		drain();

		// random part across register settings, extremes included
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: reg_write(ADDR_FILE_LEN, 32'hFFFF_FFFF);
				1: reg_write(ADDR_FILE_LEN, 32'd44);
				2: reg_write(ADDR_FILE_LEN, $urandom_range(45, 200000));
				3: reg_write(ADDR_FILE_LEN, $urandom);
				4: reg_write(ADDR_FILE_LEN, 32'd45);
				default: reg_write(ADDR_FILE_LEN, 32'd0);
			endcase
			n_headers = 0;
			while (n_headers < 3) begin
				random_header();
				n_headers++;
				if (ph == 5 && n_headers == 1) quiet_tail = 1;
				send_header();
				if (ph == 2 && n_headers == 1) drain();  // sender waits mid-phase too
			end
			drain();
		end

		if (errors == 0)
			$display("wav_header_parser_top_tb: clean");
		else
			$display("wav_header_parser_top_tb: errors");
		$finish;
	end

	// watchdog
	initial begin
		#20ms;
		$display("wav_header_parser_top_tb: errors");
		$finish;
	end

endmodule
